// ===== design/ttt_pkg.sv =====
package ttt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ID_BITS       = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TXN_W         = 16;
  localparam int PEER_W        = 48;
  localparam int TIME_W        = 32;
  localparam int CFG_W         = 24;
  localparam int RTT_W         = 16;
  localparam int CFG_IDX_W     = 2;

  localparam logic [TIME_W-1:0] RTT_CLAMP     = 32'h0000_fffe;
  localparam logic [CFG_W-1:0]  SHORT_RESET   = 24'd1000;
  localparam logic [CFG_W-1:0]  FULL_RESET    = 24'd4000;

  typedef enum logic [2:0] {
    MODE_ISSUE   = 3'd0,
    MODE_ONESHOT = 3'd1,
    MODE_RESP    = 3'd2,
    MODE_ERROR   = 3'd3,
    MODE_TICK    = 3'd4,
    MODE_CANCEL  = 3'd5
  } mode_e;

  typedef enum logic [3:0] {
    EV_ISSUED    = 4'd0,
    EV_FULL      = 4'd1,
    EV_ONESHOT   = 4'd2,
    EV_RESPONSE  = 4'd3,
    EV_ERROR     = 4'd4,
    EV_UNKNOWN   = 4'd5,
    EV_SPOOFED   = 4'd6,
    EV_SHORT     = 4'd7,
    EV_TIMEOUT   = 4'd8,
    EV_CANCELLED = 4'd9,
    EV_IDLE      = 4'd10
  } event_e;

  typedef enum logic [1:0] {
    CFG_SHORT = 2'd0,
    CFG_FULL  = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_ALLOC, S_SCAN1, S_SCAN2, S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_ACCEPT, CMD_FULL, CMD_ALLOC, CMD_REPLY, CMD_SCAN_START,
    CMD_SCAN1, CMD_SCAN2, CMD_FINISH, CMD_IDLE_EV
  } cmd_e;

  typedef struct packed {
    logic [2:0] mode;
    logic       full;
    logic       ctr_pending;
    logic       out_free;
    logic       stall1;
    logic       stall2;
    logic       idx_last;
  } status_t;

endpackage

// ===== design/ttt_ctrl.sv =====
module ttt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ttt_pkg::status_t status_i,
  output ttt_pkg::cmd_e    cmd_o
);
  import ttt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_ACCEPT;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (status_i.mode)
          MODE_ISSUE: begin
            if (status_i.full) begin
              cmd_o = CMD_FULL;
              if (status_i.out_free) state_d = S_IDLE;
            end else begin
              state_d = S_ALLOC;
            end
          end
          MODE_ONESHOT: state_d = S_ALLOC;
          MODE_RESP, MODE_ERROR, MODE_CANCEL: begin
            cmd_o = CMD_REPLY;
            if (status_i.out_free) state_d = S_IDLE;
          end
          MODE_TICK: begin
            cmd_o   = CMD_SCAN_START;
            state_d = S_SCAN1;
          end
          default: begin
            cmd_o = CMD_IDLE_EV;
            if (status_i.out_free) state_d = S_IDLE;
          end
        endcase
      end
      S_ALLOC: begin
        cmd_o = CMD_ALLOC;
        if (status_i.out_free && !status_i.ctr_pending) state_d = S_IDLE;
      end
      S_SCAN1: begin
        cmd_o = CMD_SCAN1;
        if (!status_i.stall1 && status_i.idx_last) state_d = S_SCAN2;
      end
      S_SCAN2: begin
        cmd_o = CMD_SCAN2;
        if (!status_i.stall2 && status_i.idx_last) state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o = CMD_FINISH;
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== design/ttt_dp.sv =====
module ttt_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ttt_pkg::cmd_e                          cmd_i,
  output ttt_pkg::status_t                       status_o,
  input  logic [2:0]                             in_mode_i,
  input  logic [ttt_pkg::TXN_W-1:0]              in_txn_i,
  input  logic [ttt_pkg::PEER_W-1:0]             in_peer_i,
  input  logic [ttt_pkg::TIME_W-1:0]             in_now_i,
  input  logic                                   cfg_we_i,
  input  logic [ttt_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [ttt_pkg::CFG_W-1:0]              cfg_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [3:0]                             out_kind_o,
  output logic [ttt_pkg::TXN_W-1:0]              out_txn_o,
  output logic [ttt_pkg::RTT_W-1:0]              out_rtt_o,
  output logic                                   out_last_o
);
  import ttt_pkg::*;

  logic [2:0]        mode_q;
  logic [TXN_W-1:0]  txn_in_q;
  logic [PEER_W-1:0] peer_in_q;
  logic [TIME_W-1:0] now_q;
  logic [CFG_W-1:0]  short_q, full_lim_q;

  logic [TABLE_ENTRIES-1:0] valid_q, sr_q;
  logic [TXN_W-1:0]  tab_txn_q  [TABLE_ENTRIES];
  logic [PEER_W-1:0] tab_peer_q [TABLE_ENTRIES];
  logic [TIME_W-1:0] tab_sent_q [TABLE_ENTRIES];

  logic [ID_BITS-1:0] ctr_q, ctr_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               pend_v_q, pend_v_d;
  logic [3:0]         pend_kind_q, pend_kind_d;
  logic [TXN_W-1:0]   pend_txn_q, pend_txn_d;

  logic               out_v_q, out_v_d, out_last_q, out_last_d;
  logic [3:0]         out_kind_q, out_kind_d;
  logic [TXN_W-1:0]   out_txn_q, out_txn_d;
  logic [RTT_W-1:0]   out_rtt_q, out_rtt_d;
  logic               out_load;

  // Table update strobes.
  logic               wr_en, clr_en, sr_en;
  logic [IDX_W-1:0]   clr_idx;

  logic               full, hit, ctr_pend, out_free, ev1, ev2, idx_last;
  logic [IDX_W-1:0]   free_idx, hit_idx, rd_idx;
  logic [TXN_W-1:0]   ctr_txn;
  logic [TIME_W-1:0]  age;
  logic               age_neg, full_r, short_r;
  logic [RTT_W-1:0]   rtt;

  assign ctr_txn  = TXN_W'(ctr_q);
  assign full     = &valid_q;
  assign out_free = !out_v_q || out_ready_i;
  assign idx_last = (idx_q == IDX_W'(TABLE_ENTRIES - 1));

  always_comb begin
    free_idx = '0;
    hit      = 1'b0;
    hit_idx  = '0;
    ctr_pend = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IDX_W'(i);
      if (valid_q[i] && tab_txn_q[i] == txn_in_q) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (valid_q[i] && tab_txn_q[i] == ctr_txn) ctr_pend = 1'b1;
    end
  end

  // One table read port, shared by reply lookup and tick scan.
  assign rd_idx  = (cmd_i == CMD_REPLY) ? hit_idx : idx_q;
  assign age     = now_q - tab_sent_q[rd_idx];
  assign age_neg = age[TIME_W-1];
  assign full_r  = !age_neg && (age >= TIME_W'(full_lim_q));
  assign short_r = !age_neg && (age >= TIME_W'(short_q));
  assign rtt     = age_neg ? '0 : ((age > RTT_CLAMP) ? RTT_W'(RTT_CLAMP) : age[RTT_W-1:0]);
  assign ev1     = valid_q[idx_q] && !sr_q[idx_q] && !full_r && short_r;
  assign ev2     = valid_q[idx_q] && full_r;

  always_comb begin
    status_o.mode        = mode_q;
    status_o.full        = full;
    status_o.ctr_pending = ctr_pend;
    status_o.out_free    = out_free;
    status_o.stall1      = ev1 && pend_v_q && !out_free;
    status_o.stall2      = ev2 && pend_v_q && !out_free;
    status_o.idx_last    = idx_last;
  end

  always_comb begin
    ctr_d       = ctr_q;
    idx_d       = idx_q;
    pend_v_d    = pend_v_q;
    pend_kind_d = pend_kind_q;
    pend_txn_d  = pend_txn_q;
    out_load    = 1'b0;
    out_kind_d  = out_kind_q;
    out_txn_d   = out_txn_q;
    out_rtt_d   = out_rtt_q;
    out_last_d  = out_last_q;
    wr_en       = 1'b0;
    clr_en      = 1'b0;
    clr_idx     = rd_idx;
    sr_en       = 1'b0;
    case (cmd_i)
      CMD_FULL, CMD_IDLE_EV: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = (cmd_i == CMD_FULL) ? EV_FULL : EV_IDLE;
          out_txn_d  = '0;
          out_rtt_d  = '0;
          out_last_d = 1'b1;
        end
      end
      CMD_ALLOC: begin
        if (out_free) begin
          ctr_d = ctr_q + 1'b1;
          if (!ctr_pend) begin
            out_load   = 1'b1;
            out_kind_d = (mode_q == MODE_ISSUE) ? EV_ISSUED : EV_ONESHOT;
            out_txn_d  = ctr_txn;
            out_rtt_d  = '0;
            out_last_d = 1'b1;
            wr_en      = (mode_q == MODE_ISSUE);
          end
        end
      end
      CMD_REPLY: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_txn_d  = txn_in_q;
          out_rtt_d  = '0;
          out_last_d = 1'b1;
          if (!hit) begin
            out_kind_d = EV_UNKNOWN;
          end else if (mode_q == MODE_CANCEL) begin
            out_kind_d = EV_CANCELLED;
            clr_en     = 1'b1;
          end else if (tab_peer_q[rd_idx] != peer_in_q) begin
            out_kind_d = EV_SPOOFED;
          end else begin
            out_kind_d = (mode_q == MODE_RESP) ? EV_RESPONSE : EV_ERROR;
            out_rtt_d  = rtt;
            clr_en     = 1'b1;
          end
        end
      end
      CMD_SCAN_START: begin
        idx_d    = '0;
        pend_v_d = 1'b0;
      end
      CMD_SCAN1, CMD_SCAN2: begin
        if (!(((cmd_i == CMD_SCAN1) ? ev1 : ev2) && pend_v_q && !out_free)) begin
          idx_d = idx_last ? '0 : idx_q + 1'b1;
          if ((cmd_i == CMD_SCAN1) ? ev1 : ev2) begin
            if (pend_v_q) begin
              out_load   = 1'b1;
              out_kind_d = pend_kind_q;
              out_txn_d  = pend_txn_q;
              out_rtt_d  = '0;
              out_last_d = 1'b0;
            end
            pend_v_d    = 1'b1;
            pend_kind_d = (cmd_i == CMD_SCAN1) ? EV_SHORT : EV_TIMEOUT;
            pend_txn_d  = tab_txn_q[idx_q];
            sr_en       = (cmd_i == CMD_SCAN1);
            clr_en      = (cmd_i == CMD_SCAN2);
          end
        end
      end
      CMD_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = pend_v_q ? pend_kind_q : EV_IDLE;
          out_txn_d  = pend_v_q ? pend_txn_q : '0;
          out_rtt_d  = '0;
          out_last_d = 1'b1;
        end
      end
      default: ;
    endcase
    out_v_d = out_load ? 1'b1 : (out_v_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      sr_q       <= '0;
      ctr_q      <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      short_q    <= SHORT_RESET;
      full_lim_q <= FULL_RESET;
    end else begin
      ctr_q    <= ctr_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (wr_en) begin
        valid_q[free_idx] <= 1'b1;
        sr_q[free_idx]    <= 1'b0;
      end
      if (clr_en) valid_q[clr_idx] <= 1'b0;
      if (sr_en) sr_q[idx_q] <= 1'b1;
      if (cfg_we_i && cfg_idx_i == CFG_SHORT) short_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_FULL) full_lim_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_ACCEPT) begin
      mode_q    <= in_mode_i;
      txn_in_q  <= in_txn_i;
      peer_in_q <= in_peer_i;
      now_q     <= in_now_i;
    end
    if (wr_en) begin
      tab_txn_q[free_idx]  <= ctr_txn;
      tab_peer_q[free_idx] <= peer_in_q;
      tab_sent_q[free_idx] <= now_q;
    end
    idx_q       <= idx_d;
    pend_kind_q <= pend_kind_d;
    pend_txn_q  <= pend_txn_d;
    out_kind_q  <= out_kind_d;
    out_txn_q   <= out_txn_d;
    out_rtt_q   <= out_rtt_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_v_q;
  assign out_kind_o  = out_kind_q;
  assign out_txn_o   = out_txn_q;
  assign out_rtt_o   = out_rtt_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== design/transaction_tracker_with_timeouts.sv =====
// An issue with room or a oneshot beat passes decide and then alloc, which steps the id counter
// past every id still pending; a full issue, response, error, cancel and unused modes end in decide.
// A tick walks the table twice, one entry per cycle unless a found event waits on the result register.
// Input beats are taken one at a time; the output register frees the input side early.
// Reset (rst_ni, asynchronous, active low) empties the table, zeroes the id counter and
// loads the timeouts with 1000 and 4000 ms; no clearing pass is needed.
module transaction_tracker_with_timeouts (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input beats.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, lowest bit up: txn_in[15:0], endpoint[63:16], now_ms[95:64].
  input  logic [95:0]                       s_axis_tdata,
  // tuser: mode[2:0].
  input  logic [2:0]                        s_axis_tuser,
  // Result beats.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata, lowest bit up: txn_out[15:0], rtt_ms[31:16].
  output logic [31:0]                       m_axis_tdata,
  // tuser: event_kind[3:0].
  output logic [3:0]                        m_axis_tuser,
  // tlast marks the final result beat caused by one input beat.
  output logic                              m_axis_tlast,
  // Configuration writes: index 0 short timeout, index 1 full timeout.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ttt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ttt_pkg::CFG_W-1:0]         cfg_data_i
);
  import ttt_pkg::*;

  status_t          status;
  cmd_e             cmd;
  logic [TXN_W-1:0] out_txn;
  logic [RTT_W-1:0] out_rtt;

  // Registers are always writable; they must only be written while the block is idle, which the block does not enforce.
  assign cfg_ready_o = 1'b1;

  // The controller sequences the lookup, id search and the two tick passes;
  // the datapath holds the table, the id counter and the result register.
  ttt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ttt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_mode_i   (s_axis_tuser),
    .in_txn_i    (s_axis_tdata[15:0]),
    .in_peer_i   (s_axis_tdata[63:16]),
    .in_now_i    (s_axis_tdata[95:64]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_idx_i   (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_txn_o   (out_txn),
    .out_rtt_o   (out_rtt),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_rtt, out_txn};

endmodule

// ===== design/ttt_checker.sv =====
module ttt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import ttt_pkg::*;

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // The block goes busy right after taking an input beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // Only events of known kinds come out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= EV_IDLE)
    else $error("bad event kind");

  // Only response and error events carry a round trip time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != EV_RESPONSE && m_axis_tuser != EV_ERROR
      |-> m_axis_tdata[31:16] == 16'd0)
    else $error("rtt on a non-response event");

endmodule

bind transaction_tracker_with_timeouts ttt_checker u_ttt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
